FILE: rtl/core/svf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the stereo state-variable filter
// no dependencies
package svf_pkg;

  // output response select
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_HIGH = 2'd2;
  localparam logic [1:0] MODE_BAND = 2'd3;

  // register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_COEFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_POSITION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // channel count codes
  localparam logic [1:0] CH_NONE   = 2'd0;
  localparam logic [1:0] CH_MONO   = 2'd1;
  localparam logic [1:0] CH_STEREO = 2'd2;

  localparam int unsigned COEF_W = 15;

  typedef struct packed {
    logic       start;
    logic       run;
    logic [1:0] mode;
  } lane_ctrl_t;

  typedef struct packed {
    logic start;
    logic pan_en;
  } mix_ctrl_t;

endpackage

FILE: rtl/core/svf_lane.sv
`timescale 1ns / 1ps
// one channel of the state-variable filter with a shared multiplier
// depends on svf_pkg
module svf_lane #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  svf_pkg::lane_ctrl_t                    ctrl,
  input  logic [svf_pkg::COEF_W-1:0]             freq_coeff,
  input  logic [svf_pkg::COEF_W-1:0]             damping,
  input  logic signed [SAMPLE_WIDTH-1:0]         x_in,
  output logic signed [SAMPLE_WIDTH+3:0]         y_out,
  output logic                                   done
);
  import svf_pkg::*;

  localparam int STW  = SAMPLE_WIDTH + 4;
  localparam int PW   = STW + COEF_W + 1;
  localparam int RW   = PW - 14;
  localparam int SUMW = STW + 3;

  typedef enum logic [2:0] {L_IDLE, L_MUL1, L_LOW, L_HIGH, L_MUL3, L_BAND} lstate_t;

  lstate_t state_r;
  logic signed [STW-1:0] low_r, band_r, high_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [STW-1:0] mul_a;
  logic [COEF_W-1:0] mul_c;
  logic signed [STW-1:0] low_nxt, high_nxt, band_nxt;
  logic signed [RW-1:0] rnd;
  logic signed [STW-1:0] y_r;
  logic done_r;

  function automatic logic signed [RW-1:0] rnd14(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + $signed({{(PW-14){1'b0}}, 1'b1, {13{1'b0}}});
    return t[PW-1:14];
  endfunction

  function automatic logic signed [STW-1:0] sat_st(input logic signed [SUMW-1:0] v);
    logic fits;
    fits = (&v[SUMW-1:STW-1]) || !(|v[SUMW-1:STW-1]);
    if (fits) return v[STW-1:0];
    else if (v[SUMW-1]) return {1'b1, {(STW-1){1'b0}}};
    else return {1'b0, {(STW-1){1'b1}}};
  endfunction

  // operand select for the single multiplier
  always_comb begin
    case (state_r)
      L_MUL1: begin
        mul_a = band_r;
        mul_c = freq_coeff;
      end
      L_LOW: begin
        mul_a = band_r;
        mul_c = damping;
      end
      L_MUL3: begin
        mul_a = high_r;
        mul_c = freq_coeff;
      end
      default: begin
        mul_a = band_r;
        mul_c = freq_coeff;
      end
    endcase
  end

  assign prod_nxt = mul_a * $signed({1'b0, mul_c});
  assign rnd      = rnd14(prod_r);
  assign low_nxt  = sat_st(SUMW'(low_r) + SUMW'(rnd));
  assign high_nxt = sat_st(SUMW'(x_r) - SUMW'(low_r) - SUMW'(rnd));
  assign band_nxt = sat_st(SUMW'(band_r) + SUMW'(rnd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
      low_r   <= '0;
      band_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (ctrl.start) begin
            x_r <= x_in;
            if (ctrl.run) begin
              state_r <= L_MUL1;
            end else begin
              y_r    <= STW'(x_in);
              done_r <= 1'b1;
            end
          end
        end
        L_MUL1: begin
          prod_r  <= prod_nxt;
          state_r <= L_LOW;
        end
        L_LOW: begin
          low_r   <= low_nxt;
          prod_r  <= prod_nxt;
          state_r <= L_HIGH;
        end
        L_HIGH: begin
          high_r  <= high_nxt;
          state_r <= L_MUL3;
        end
        L_MUL3: begin
          prod_r  <= prod_nxt;
          state_r <= L_BAND;
        end
        L_BAND: begin
          band_r <= band_nxt;
          case (ctrl.mode)
            MODE_LOW:  y_r <= low_r;
            MODE_HIGH: y_r <= high_r;
            default:   y_r <= band_nxt;
          endcase
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign y_out = y_r;
  assign done  = done_r;

endmodule

FILE: rtl/core/svf_mix.sv
`timescale 1ns / 1ps
// pan crossfeed and output saturation that merges the two lanes
// depends on svf_pkg
module svf_mix #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  svf_pkg::mix_ctrl_t                   ctrl,
  input  logic signed [svf_pkg::CFG_DATA_W-1:0] pan_position,
  input  logic signed [SAMPLE_WIDTH+3:0]       y_l,
  input  logic signed [SAMPLE_WIDTH+3:0]       y_r,
  output logic signed [SAMPLE_WIDTH-1:0]       out_l,
  output logic signed [SAMPLE_WIDTH-1:0]       out_r,
  output logic                                 done
);
  import svf_pkg::*;

  localparam int STW = SAMPLE_WIDTH + 4;
  localparam int KW  = 17;
  localparam int MW  = STW + KW;
  localparam int AW  = MW + 1;
  localparam int QW  = AW - 15;

  typedef enum logic [2:0] {M_IDLE, M_P0, M_P1, M_P2, M_P3, M_P4} mstate_t;

  mstate_t state_r;
  logic signed [KW-1:0] p_c, k_ll, k_rl, k_lr, k_rr, mul_k;
  logic signed [STW-1:0] mul_a;
  logic signed [MW-1:0] prod_r, prod_nxt, acc_r;
  logic signed [AW-1:0] sum;
  logic signed [SAMPLE_WIDTH-1:0] out_l_r, out_r_r, fin;
  logic done_r;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(
    input logic signed [QW-1:0] v
  );
    logic fits;
    fits = (&v[QW-1:SAMPLE_WIDTH-1]) || !(|v[QW-1:SAMPLE_WIDTH-1]);
    if (fits) return v[SAMPLE_WIDTH-1:0];
    else if (v[QW-1]) return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    else return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  endfunction

  function automatic logic signed [QW-1:0] rnd15(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    t = v + $signed({{(AW-15){1'b0}}, 1'b1, {14{1'b0}}});
    return t[AW-1:15];
  endfunction

  // clamp pan to -1 .. +1 and form the crossfeed gains
  always_comb begin
    p_c = KW'(pan_position);
    if (p_c > 17'sd16384) p_c = 17'sd16384;
    if (p_c < -17'sd16384) p_c = -17'sd16384;
    if (p_c <= 17'sd0) begin
      k_ll = 17'sd32768 + p_c;
      k_rl = -p_c;
      k_lr = '0;
      k_rr = 17'sd32768 + (p_c <<< 1);
    end else begin
      k_ll = 17'sd32768 - (p_c <<< 1);
      k_rl = '0;
      k_lr = p_c;
      k_rr = 17'sd32768 - p_c;
    end
  end

  always_comb begin
    case (state_r)
      M_P0: begin
        mul_a = y_l;
        mul_k = k_ll;
      end
      M_P1: begin
        mul_a = y_r;
        mul_k = k_rl;
      end
      M_P2: begin
        mul_a = y_l;
        mul_k = k_lr;
      end
      M_P3: begin
        mul_a = y_r;
        mul_k = k_rr;
      end
      default: begin
        mul_a = y_l;
        mul_k = k_ll;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_k;
  assign sum      = AW'(acc_r) + AW'(prod_r);
  assign fin      = sat_out(rnd15(sum));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (ctrl.start) begin
            if (ctrl.pan_en) begin
              state_r <= M_P0;
            end else begin
              out_l_r <= sat_out(QW'(y_l));
              out_r_r <= sat_out(QW'(y_r));
              done_r  <= 1'b1;
            end
          end
        end
        M_P0: begin
          prod_r  <= prod_nxt;
          state_r <= M_P1;
        end
        M_P1: begin
          acc_r   <= prod_r;
          prod_r  <= prod_nxt;
          state_r <= M_P2;
        end
        M_P2: begin
          out_l_r <= fin;
          prod_r  <= prod_nxt;
          state_r <= M_P3;
        end
        M_P3: begin
          acc_r   <= prod_r;
          prod_r  <= prod_nxt;
          state_r <= M_P4;
        end
        M_P4: begin
          out_r_r <= fin;
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign out_l = out_l_r;
  assign out_r = out_r_r;
  assign done  = done_r;

endmodule

FILE: rtl/core/stereo_svf_filter_with_pan.sv
`timescale 1ns / 1ps
// top level: stereo state-variable filter with pan crossfeed
// depends on svf_pkg, svf_lane, svf_mix
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------
//  in_      | slave     | one frame: left_in, right_in
//  out_     | master    | one frame: left_out, right_out
//  cfg_     | write     | register index and value, no read-back
//
// from acceptance a frame runs through the two filter lanes (one multiplier
// each, three products per sample), then through the crossfeed merge in
// stereo (one multiplier, four products), then into the result register.
// with the filter off the lanes pass samples through, and without pan the
// merge only saturates. the next frame is taken once the previous one has
// left the lanes and merge, even while its result still waits on out_tready.
// reset is synchronous, active low, and clears filter state and registers
// to their defaults.
module stereo_svf_filter_with_pan #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input frames
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,  // left_in, right_in
  // result frames
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata, // left_out, right_out
  // configuration writes
  input  logic                                    cfg_wr_en,
  input  logic [svf_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [svf_pkg::CFG_DATA_W-1:0]          cfg_wdata
);
  import svf_pkg::*;

  localparam int DW  = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int STW = SAMPLE_WIDTH + 4;

  typedef enum logic [1:0] {T_IDLE, T_LANE, T_MIX, T_HOLD} tstate_t;

  tstate_t state_r;

  // configuration registers
  logic [1:0]                   mode_r;
  logic [COEF_W-1:0]            freq_r;
  logic [COEF_W-1:0]            damp_r;
  logic signed [CFG_DATA_W-1:0] pan_r;
  logic [1:0]                   chan_r;

  logic signed [SAMPLE_WIDTH-1:0] xl_r, xr_r;
  logic       lane_start_r;
  logic [1:0] lane_done_r;
  logic       mix_start_r;
  logic       out_valid_r;
  logic [DW-1:0] out_data_r;

  lane_ctrl_t ctrl_l, ctrl_r;
  mix_ctrl_t  ctrl_m;
  logic signed [STW-1:0] yl, yr, yr_sel;
  logic done_l, done_r;
  logic signed [SAMPLE_WIDTH-1:0] mix_l, mix_r;
  logic mix_done;
  logic out_free;
  logic out_load;
  logic in_beat;

  assign in_tready = (state_r == T_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  // a merged frame moves into the result register this cycle
  assign out_load  = out_free && (((state_r == T_MIX) && mix_done) || (state_r == T_HOLD));

  // left lane filters unless the mode is none or no channel is active; right lane also needs more than mono
  assign ctrl_l.start = lane_start_r;
  assign ctrl_l.run   = (mode_r != MODE_NONE) && (chan_r != CH_NONE);
  assign ctrl_l.mode  = mode_r;
  assign ctrl_r.start = lane_start_r;
  assign ctrl_r.run   = (mode_r != MODE_NONE) && (chan_r != CH_NONE) && (chan_r != CH_MONO);
  assign ctrl_r.mode  = mode_r;

  // mono forces the right output to silence
  assign yr_sel       = (chan_r == CH_MONO) ? '0 : yr;
  assign ctrl_m.start  = mix_start_r;
  assign ctrl_m.pan_en = (chan_r == CH_STEREO);

  svf_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_l (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_l),
    .freq_coeff (freq_r),
    .damping    (damp_r),
    .x_in       (xl_r),
    .y_out      (yl),
    .done       (done_l)
  );

  svf_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_r (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_r),
    .freq_coeff (freq_r),
    .damping    (damp_r),
    .x_in       (xr_r),
    .y_out      (yr),
    .done       (done_r)
  );

  svf_mix #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl_m),
    .pan_position (pan_r),
    .y_l          (yl),
    .y_r          (yr_sel),
    .out_l        (mix_l),
    .out_r        (mix_r),
    .done         (mix_done)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
      freq_r <= '0;
      damp_r <= 15'd16384;
      pan_r  <= '0;
      chan_r <= CH_STEREO;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FILTER_MODE:   mode_r <= cfg_wdata[1:0];
        CFG_FREQ_COEFF:    freq_r <= cfg_wdata[COEF_W-1:0];
        CFG_DAMPING:       damp_r <= cfg_wdata[COEF_W-1:0];
        CFG_PAN_POSITION:  pan_r  <= cfg_wdata;
        CFG_CHANNEL_COUNT: chan_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // frame sequencing and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      lane_start_r <= 1'b0;
      lane_done_r  <= '0;
      mix_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      lane_start_r <= 1'b0;
      mix_start_r  <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (in_beat) begin
            xl_r         <= in_tdata[SAMPLE_WIDTH-1:0];
            xr_r         <= in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            lane_start_r <= 1'b1;
            lane_done_r  <= '0;
            state_r      <= T_LANE;
          end
        end
        T_LANE: begin
          // lanes may finish on different cycles when only one runs
          if ((lane_done_r[0] || done_l) && (lane_done_r[1] || done_r)) begin
            mix_start_r <= 1'b1;
            state_r     <= T_MIX;
          end else begin
            lane_done_r <= lane_done_r | {done_r, done_l};
          end
        end
        T_MIX: begin
          if (mix_done) begin
            if (out_free) begin
              out_data_r  <= DW'({mix_r, mix_l});
              state_r     <= T_IDLE;
            end else begin
              state_r <= T_HOLD;
            end
          end
        end
        T_HOLD: begin
          // merge outputs stay put until the result register frees up
          if (out_free) begin
            out_data_r  <= DW'({mix_r, mix_l});
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sim/tb_stereo_svf_filter_with_pan.sv
`timescale 1ns / 1ps
// self-checking bench for stereo_svf_filter_with_pan: a directed table of frames and
// register settings, then random phases, scored by typed-in values or a filter model
// depends on svf_pkg and the rtl top level
module tb_stereo_svf_filter_with_pan;
  import svf_pkg::*;

  localparam int SW = 16;
  localparam int DW = ((2*SW+7)/8)*8;
  localparam int ST_W = SW + 4;          // filter state is Q4.15
  localparam int COEF_FRAC = 14;         // f and damping are Q1.14
  localparam int DRAIN_CYCLES = 24;      // extra wait after the last result
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat and no register write
  localparam int HOLD_CYCLES = 200;      // long receiver stall to back the block up
  localparam int HOLD_AFTER = 300;       // result count that arms the long stall
  localparam int RAND_PHASES = 14;
  localparam int FRAMES_PER_PHASE = 125;
  localparam int QUIET_PHASES = 3;       // closing phases run without any idling
  localparam int MAX_REPORTS = 10;

  // channel count code with no name in the package: both lanes filtered, no pan
  localparam logic [1:0] CH_DUAL_RAW = 2'd3;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] l;
  } frame_t;

  // one line of the directed table: either a full register setting or a frame
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  mode;
    logic [14:0] f;
    logic [14:0] q;
    logic [15:0] pan;
    logic [1:0]  ch;
    logic [15:0] l;
    logic [15:0] r;
    logic        known;  // expected result typed in below
    logic [15:0] el;
    logic [15:0] er;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;   // left_in, right_in
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;       // left_out, right_out
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // bench copy of the register file, starts at the reset values
  logic [1:0]         cur_mode = MODE_NONE;
  logic [14:0]        cur_f = 15'd0;
  logic [14:0]        cur_q = 15'd16384;
  logic signed [15:0] cur_pan = 16'sd0;
  logic [1:0]         cur_ch = CH_STEREO;

  // bench copy of the filter state, one entry per lane
  longint low_acc [2] = '{0, 0};
  longint band_acc [2] = '{0, 0};

  frame_t   expected_frames [$];
  dir_row_t dir_tab [$];

  int  mismatches = 0;
  int  frames_out = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  held = 1'b0;
  bit  quiet = 1'b0;

  stereo_svf_filter_with_pan #(.SAMPLE_WIDTH(SW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // add half an lsb, then floor divide by 2^s (arithmetic shift on longint)
  function automatic longint rnd_shr(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // one chamberlin update on lane c, returns the selected response
  function automatic longint svf_lane_step(input int c, input longint x);
    longint f;
    longint q;
    longint lo;
    longint bd;
    longint hp;
    f = longint'(cur_f);
    q = longint'(cur_q);
    lo = low_acc[c];
    bd = band_acc[c];
    lo = clip(lo + rnd_shr(f * bd, COEF_FRAC), ST_W);
    hp = clip(x - lo - rnd_shr(q * bd, COEF_FRAC), ST_W);
    bd = clip(bd + rnd_shr(f * hp, COEF_FRAC), ST_W);
    low_acc[c] = lo;
    band_acc[c] = bd;
    case (cur_mode)
      MODE_LOW:  return lo;
      MODE_HIGH: return hp;
      default:   return bd;
    endcase
  endfunction

  // full frame: per-lane filter, then the pan crossfeed in stereo
  function automatic frame_t svf_predict(input logic [15:0] li, input logic [15:0] ri);
    longint xl;
    longint xr;
    longint yl;
    longint yr;
    longint p;
    longint ll;
    longint rl;
    longint lr;
    longint rr;
    longint mix_l;
    frame_t res;
    xl = longint'($signed(li));
    xr = longint'($signed(ri));
    yl = xl;
    yr = xr;
    // channel count zero leaves both samples as they came in
    if (cur_ch != CH_NONE) begin
      yl = (cur_mode == MODE_NONE) ? xl : svf_lane_step(0, xl);
      if (cur_ch == CH_MONO) begin
        yr = 0;
      end else begin
        yr = (cur_mode == MODE_NONE) ? xr : svf_lane_step(1, xr);
        if (cur_ch == CH_STEREO) begin
          p = longint'(cur_pan);
          if (p > 16384) p = 16384;
          if (p < -16384) p = -16384;
          if (p <= 0) begin
            ll = 32768 + p;
            rl = -p;
            lr = 0;
            rr = 32768 + 2 * p;
          end else begin
            ll = 32768 - 2 * p;
            rl = 0;
            lr = p;
            rr = 32768 - p;
          end
          mix_l = rnd_shr(yl * ll + yr * rl, 15);
          yr = rnd_shr(yl * lr + yr * rr, 15);
          yl = mix_l;
        end
      end
    end
    yl = clip(yl, SW);
    yr = clip(yr, SW);
    res.l = yl[15:0];
    res.r = yr[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  // input side: optional short gap, then offer one frame until it is taken
  task automatic put_frame(input logic [15:0] l, input logic [15:0] r,
                           input logic known, input logic [15:0] el,
                           input logic [15:0] er);
    frame_t want;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r, l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // beat taken at this edge: advance the model in acceptance order
    want = svf_predict(l, r);
    if (known) begin
      want.l = el;
      want.r = er;
    end
    expected_frames.push_back(want);
  endtask

  // stop offering, wait for every result, then let the pipe settle
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // writes all five registers back to back while the block is idle
  task automatic program_regs(input logic [1:0] m, input logic [14:0] f,
                              input logic [14:0] q, input logic [15:0] p,
                              input logic [1:0] ch);
    drain_pipe();
    put_reg(CFG_FILTER_MODE, {14'd0, m});
    put_reg(CFG_FREQ_COEFF, {1'b0, f});
    put_reg(CFG_DAMPING, {1'b0, q});
    put_reg(CFG_PAN_POSITION, p);
    put_reg(CFG_CHANNEL_COUNT, {14'd0, ch});
    cfg_wr_en <= 1'b0;
    cur_mode = m;
    cur_f = f;
    cur_q = q;
    cur_pan = p;
    cur_ch = ch;
  endtask

  task automatic add_cfg_row(input logic [1:0] m, input logic [14:0] f,
                             input logic [14:0] q, input logic [15:0] p,
                             input logic [1:0] ch);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.mode = m;
    row.f = f;
    row.q = q;
    row.pan = p;
    row.ch = ch;
    dir_tab.push_back(row);
  endtask

  task automatic add_frame_row(input logic [15:0] l, input logic [15:0] r,
                               input logic known, input logic [15:0] el,
                               input logic [15:0] er);
    dir_row_t row;
    row = '0;
    row.l = l;
    row.r = r;
    row.known = known;
    row.el = el;
    row.er = er;
    dir_tab.push_back(row);
  endtask

  // samples lean on the rails now and then so saturation is reached
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // coefficient mix: mostly moderate f for stable filters, some extremes
  function automatic logic [14:0] rand_coef(input bit moderate);
    case ($urandom_range(0, 7))
      0:       return 15'd0;
      1:       return 15'h7FFF;
      2:       return 15'($urandom);
      default: return moderate ? 15'($urandom_range(50, 4000)) : 15'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_pan();
    case ($urandom_range(0, 9))
      0:       return 16'(-16384);
      1:       return 16'(16384);
      2:       return 16'($urandom);  // often out of range, clamped by the block
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [1:0] rand_channels();
    case ($urandom_range(0, 7))
      0:       return CH_NONE;
      1:       return CH_MONO;
      2:       return CH_DUAL_RAW;
      default: return CH_STEREO;
    endcase
  endfunction

  // ---------------------------------------------------------------- result side

  // scores one output beat against the oldest pending frame
  task automatic check_frame(input logic [DW-1:0] d);
    frame_t got;
    frame_t want;
    got.l = d[15:0];
    got.r = d[31:16];
    frames_out++;
    if (expected_frames.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: unexpected result beat left=%0d right=%0d", $realtime,
                 $signed(got.l), $signed(got.r));
      mismatches++;
    end else begin
      want = expected_frames.pop_front();
      if (got.l !== want.l || got.r !== want.r) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: frame %0d left exp %0d got %0d, right exp %0d got %0d",
                   $realtime, frames_out, $signed(want.l), $signed(got.l),
                   $signed(want.r), $signed(got.r));
        mismatches++;
      end
    end
  endtask

  // receiver: short random stalls, one long hold while frames keep coming,
  // and a steady ready during the quiet tail
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_frame(out_tdata);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!held && frames_out >= HOLD_AFTER && in_tvalid) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: any beat or register write counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: filter off, stereo, centered pan, so frames pass unchanged
    add_frame_row(16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000);
    add_frame_row(16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF);
    add_frame_row(16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000);
    add_frame_row(16'h0001, 16'hFFFF, 1'b1, 16'h0001, 16'hFFFF);
    // mono: left passes, right forced to zero
    add_cfg_row(MODE_NONE, 15'd0, 15'd16384, 16'd0, CH_MONO);
    add_frame_row(16'd12345, 16'd999, 1'b1, 16'd12345, 16'd0);
    // channel count zero: untouched passthrough
    add_cfg_row(MODE_NONE, 15'd0, 15'd16384, 16'd0, CH_NONE);
    add_frame_row(16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF);
    // channel count three: both lanes, no pan matrix
    add_cfg_row(MODE_NONE, 15'd0, 15'd16384, 16'd0, CH_DUAL_RAW);
    add_frame_row(16'd100, 16'(-200), 1'b1, 16'd100, 16'(-200));
    // hard left: average of both into left, right silent
    add_cfg_row(MODE_NONE, 15'd0, 15'd16384, 16'(-16384), CH_STEREO);
    add_frame_row(16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h0000);
    // hard right: mirror image
    add_cfg_row(MODE_NONE, 15'd0, 15'd16384, 16'(16384), CH_STEREO);
    add_frame_row(16'h8000, 16'h8000, 1'b1, 16'h0000, 16'h8000);
    // pan beyond +1 clamps to hard right
    add_cfg_row(MODE_NONE, 15'd0, 15'd16384, 16'h7FFF, CH_STEREO);
    add_frame_row(16'd100, 16'd300, 1'b1, 16'd0, 16'd200);
    // pan beyond -1 clamps to hard left
    add_cfg_row(MODE_NONE, 15'd0, 15'd16384, 16'h8000, CH_STEREO);
    add_frame_row(16'd100, 16'd300, 1'b1, 16'd200, 16'd0);
    // f = 0 with zero state: high-pass is x itself, band-pass stays at zero
    add_cfg_row(MODE_HIGH, 15'd0, 15'd0, 16'd0, CH_MONO);
    add_frame_row(16'h8000, 16'd5, 1'b1, 16'h8000, 16'd0);
    add_cfg_row(MODE_BAND, 15'd0, 15'h7FFF, 16'd0, CH_STEREO);
    add_frame_row(16'h7FFF, 16'h8000, 1'b1, 16'd0, 16'd0);
    // running filters at the coefficient extremes, scored by the model
    add_cfg_row(MODE_LOW, 15'd16384, 15'd16384, 16'd0, CH_STEREO);
    add_frame_row(16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0);
    add_frame_row(16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0);
    add_frame_row(16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0);
    add_cfg_row(MODE_HIGH, 15'h7FFF, 15'd0, 16'(-5000), CH_STEREO);
    add_frame_row(16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0);
    add_frame_row(16'h7FFF, 16'h7FFF, 1'b0, 16'd0, 16'd0);
    add_cfg_row(MODE_BAND, 15'h7FFF, 15'h7FFF, 16'd9000, CH_DUAL_RAW);
    add_frame_row(16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0);
    add_frame_row(16'd1234, 16'hFFFF, 1'b0, 16'd0, 16'd0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg)
        program_regs(dir_tab[i].mode, dir_tab[i].f, dir_tab[i].q, dir_tab[i].pan,
                     dir_tab[i].ch);
      else
        put_frame(dir_tab[i].l, dir_tab[i].r, dir_tab[i].known, dir_tab[i].el,
                  dir_tab[i].er);
    end

    // random phases: a new setting each phase, filter state carried across
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      program_regs(2'($urandom_range(0, 3)), rand_coef(1'b1), rand_coef(1'b0),
                   rand_pan(), rand_channels());
      quiet = (ph >= RAND_PHASES - QUIET_PHASES);
      repeat (FRAMES_PER_PHASE) put_frame(rand_sample(), rand_sample(), 1'b0, 16'd0, 16'd0);
    end

    drain_pipe();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: stereo_svf_filter_with_pan.f
rtl/core/svf_pkg.sv
rtl/core/svf_lane.sv
rtl/core/svf_mix.sv
rtl/core/stereo_svf_filter_with_pan.sv
sim/tb_stereo_svf_filter_with_pan.sv
